FILE: hw/rtl/rvxu_pkg.sv
package rvxu_pkg;

   localparam logic [6:0] OPC_OP     = 7'b0110011;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_LUI    = 7'b0110111;

   localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;

   // ALU funct3
   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_SLL = 3'd1;
   localparam logic [2:0] F3_SLT = 3'd2;
   localparam logic [2:0] F3_XOR = 3'd4;
   localparam logic [2:0] F3_SR  = 3'd5;
   localparam logic [2:0] F3_OR  = 3'd6;
   localparam logic [2:0] F3_AND = 3'd7;

   // load/store width
   localparam logic [2:0] F3_WORD = 3'd2;

   // branch funct3
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_ALIGN = 2'd1,
      ST_RANGE = 2'd2,
      ST_NIMP  = 2'd3
   } status_type;

endpackage

FILE: hw/rtl/rv32i_subset_execute_unit_core.sv
// channel   direction  handshake            payload
// request   in         start & !busy        req_instr_word
// response  out        rsp_strobe (1 cyc)   rsp_reg_written, rsp_dest_reg, rsp_write_value,
//                                           rsp_branch_cond, rsp_status
//
// One instruction per cycle while busy is low; each beat passes the execute register, then the response register.
// The register-file read and the data-memory read are both registered.
// Operands are forwarded from the response stage and bypassed at the register-file write.
// After reset busy stays high while all DATA_WORDS words of the data memory are swept to zero.
// The receiver cannot stall; busy is high only during that sweep.
module rv32i_subset_execute_unit_core
   import rvxu_pkg::*;
#(
   parameter int DATA_WORDS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_instr_word,
   output logic               rsp_strobe,
   output logic               rsp_reg_written,
   output logic [4:0]         rsp_dest_reg,
   output logic signed [31:0] rsp_write_value,
   output logic               rsp_branch_cond,
   output logic [1:0]         rsp_status
);

   localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
   localparam logic [29:0] WORD_LIMIT = 30'(DATA_WORDS);
   localparam logic [AW-1:0] CLR_LAST = AW'(DATA_WORDS - 1);

   logic accept;

   // clearing sweep
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;

   // register file
   logic [31:0] rf [32];
   logic [31:0] rf_vld_ff;
   logic [31:0] rs1_q_ff, rs2_q_ff;
   logic        rs1_vld_ff, rs2_vld_ff;
   logic        rs1_byp_ff, rs2_byp_ff;
   logic [31:0] byp_val_ff;
   logic        rf_we;

   // execute stage
   logic        x_vld_ff, x_vld_in;
   logic [31:0] x_instr_ff;
   logic [6:0]  opc, f7;
   logic [4:0]  rd, rs1, rs2;
   logic [2:0]  f3;
   logic [31:0] a_rf, b_rf, a, b;
   logic [31:0] imm_i, imm_s, addr;
   logic [AW-1:0] x_idx;
   logic          is_ld, is_st, has_rd, x_wr, bcond;
   logic [31:0]   value;
   status_type    status, addr_st;

   // data memory
   logic [31:0] dmem [DATA_WORDS];
   logic [31:0] dmem_q_ff;

   // response stage
   logic        m_vld_ff, m_vld_in;
   logic        m_wr_ff, m_ld_ff, m_bc_ff;
   logic [4:0]  m_rd_ff;
   logic [31:0] m_alu_ff, m_val;
   status_type  m_st_ff;

   assign busy   = clr_ff;
   assign accept = start && !clr_ff;

   // -------- clear sweep / control --------
   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == CLR_LAST) clr_in = 1'b0;
      end
      x_vld_in = accept;
      m_vld_in = x_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         x_vld_ff   <= 1'b0;
         m_vld_ff   <= 1'b0;
         rf_vld_ff  <= '0;
      end else begin
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         x_vld_ff   <= x_vld_in;
         m_vld_ff   <= m_vld_in;
         if (rf_we) rf_vld_ff[m_rd_ff] <= 1'b1;
      end
   end

   // -------- register file --------
   assign rf_we = m_vld_ff && m_wr_ff;

   always_ff @(posedge clock) begin
      if (rf_we) rf[m_rd_ff] <= m_val;
      rs1_q_ff <= rf[req_instr_word[19:15]];
      rs2_q_ff <= rf[req_instr_word[24:20]];
   end

   // valid bits and write-through bypass for a read at the write edge
   always_ff @(posedge clock) begin
      rs1_vld_ff <= rf_vld_ff[req_instr_word[19:15]];
      rs2_vld_ff <= rf_vld_ff[req_instr_word[24:20]];
      rs1_byp_ff <= rf_we && (m_rd_ff == req_instr_word[19:15]);
      rs2_byp_ff <= rf_we && (m_rd_ff == req_instr_word[24:20]);
      byp_val_ff <= m_val;
      if (accept) x_instr_ff <= req_instr_word;
   end

   // -------- execute --------
   assign opc = x_instr_ff[6:0];
   assign rd  = x_instr_ff[11:7];
   assign f3  = x_instr_ff[14:12];
   assign rs1 = x_instr_ff[19:15];
   assign rs2 = x_instr_ff[24:20];
   assign f7  = x_instr_ff[31:25];

   assign imm_i = {{20{x_instr_ff[31]}}, x_instr_ff[31:20]};
   assign imm_s = {{20{x_instr_ff[31]}}, x_instr_ff[31:25], x_instr_ff[11:7]};

   assign a_rf = rs1_byp_ff ? byp_val_ff : (rs1_vld_ff ? rs1_q_ff : '0);
   assign b_rf = rs2_byp_ff ? byp_val_ff : (rs2_vld_ff ? rs2_q_ff : '0);
   // forward from the item in the response stage
   assign a = (rf_we && m_rd_ff == rs1) ? m_val : a_rf;
   assign b = (rf_we && m_rd_ff == rs2) ? m_val : b_rf;

   assign is_ld = (opc == OPC_LOAD)  && (f3 == F3_WORD);
   assign is_st = (opc == OPC_STORE) && (f3 == F3_WORD);
   assign addr  = a + (is_st ? imm_s : imm_i);
   assign x_idx = addr[AW+1:2];

   always_comb begin
      if (addr[1:0] != 2'b00)           addr_st = ST_ALIGN;
      else if (addr[31:2] >= WORD_LIMIT) addr_st = ST_RANGE;
      else                               addr_st = ST_OK;
   end

   always_comb begin
      status = ST_OK;
      value  = '0;
      bcond  = 1'b0;
      has_rd = 1'b0;
      unique case (opc)
         OPC_OP: begin
            has_rd = 1'b1;
            if (f7 == F7_BASE) begin
               unique case (f3)
                  F3_SLL:  value = a << b[4:0];
                  F3_SR:   value = a >> b[4:0];
                  F3_ADD:  value = a + b;
                  F3_AND:  value = a & b;
                  F3_OR:   value = a | b;
                  F3_XOR:  value = a ^ b;
                  F3_SLT:  value = {31'd0, $signed(a) < $signed(b)};
                  default: status = ST_NIMP;
               endcase
            end else if (f7 == F7_ALT) begin
               unique case (f3)
                  F3_SR:   value = 32'($signed(a) >>> b[4:0]);
                  F3_ADD:  value = a - b;
                  default: status = ST_NIMP;
               endcase
            end else begin
               status = ST_NIMP;
            end
         end
         OPC_OPIMM: begin
            has_rd = 1'b1;
            unique case (f3)
               F3_SLL: begin
                  if (f7 == F7_BASE) value = a << rs2;
                  else status = ST_NIMP;
               end
               F3_SR: begin
                  if (f7 == F7_BASE)     value = a >> rs2;
                  else if (f7 == F7_ALT) value = 32'($signed(a) >>> rs2);
                  else                   status = ST_NIMP;
               end
               F3_ADD:  value = a + imm_i;
               F3_XOR:  value = a ^ imm_i;
               F3_AND:  value = a & imm_i;
               F3_OR:   value = a | imm_i;
               F3_SLT:  value = {31'd0, $signed(a) < $signed(imm_i)};
               default: status = ST_NIMP;
            endcase
         end
         OPC_LOAD: begin
            if (is_ld) begin
               has_rd = 1'b1;
               status = addr_st;
            end else begin
               status = ST_NIMP;
            end
         end
         OPC_STORE: begin
            if (is_st) status = addr_st;
            else       status = ST_NIMP;
         end
         OPC_BRANCH: begin
            unique case (f3)
               F3_BEQ:  bcond = (a == b);
               F3_BNE:  bcond = (a != b);
               F3_BLT:  bcond = $signed(a) <  $signed(b);
               F3_BGE:  bcond = $signed(a) >= $signed(b);
               F3_BLTU: bcond = (a <  b);
               F3_BGEU: bcond = (a >= b);
               default: status = ST_NIMP;
            endcase
         end
         OPC_LUI: begin
            has_rd = 1'b1;
            value  = x_instr_ff & UPPER_MASK;
         end
         default: status = ST_NIMP;
      endcase
   end

   assign x_wr = has_rd && (rd != 5'd0) && (status != ST_NIMP);

   // -------- data memory --------
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         dmem[clr_cnt_ff] <= '0;
      end else if (x_vld_ff && is_st && addr_st == ST_OK) begin
         dmem[x_idx] <= b;
      end
      if (x_vld_ff && is_ld) dmem_q_ff <= dmem[x_idx];
   end

   // -------- response register --------
   always_ff @(posedge clock) begin
      m_wr_ff  <= x_wr;
      m_rd_ff  <= x_wr ? rd : 5'd0;
      m_alu_ff <= (x_wr && !is_ld) ? value : '0;
      m_ld_ff  <= x_wr && is_ld && (addr_st == ST_OK);
      m_bc_ff  <= bcond;
      m_st_ff  <= status;
   end

   assign m_val = m_ld_ff ? dmem_q_ff : m_alu_ff;

   assign rsp_strobe      = m_vld_ff;
   assign rsp_reg_written = m_wr_ff;
   assign rsp_dest_reg    = m_rd_ff;
   assign rsp_write_value = m_val;
   assign rsp_branch_cond = m_bc_ff;
   assign rsp_status      = m_st_ff;

endmodule

FILE: hw/rtl/rvxu_checker.sv
module rvxu_checker
   import rvxu_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [31:0]        req_instr_word,
   input logic               rsp_strobe,
   input logic               rsp_reg_written,
   input logic [4:0]         rsp_dest_reg,
   input logic signed [31:0] rsp_write_value,
   input logic               rsp_branch_cond,
   input logic [1:0]         rsp_status
);

   // every accepted beat yields a response strobe
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted beat produced no response");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("response without an accepted beat");

   // busy only comes up through reset
   a_busy_rise: assert property (@(posedge clock)
      $rose(busy) |-> $past(reset))
      else $error("busy rose outside reset");

   // rd of x0 never reports a write
   a_x0_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_instr_word[11:7] == 5'd0, 2)) |-> !rsp_reg_written)
      else $error("write reported for x0");

   // not-implemented ops change nothing
   a_nimp_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_NIMP) |-> (!rsp_reg_written && !rsp_branch_cond
         && rsp_dest_reg == 5'd0 && rsp_write_value == 32'sd0))
      else $error("not-implemented op reported side effects");

endmodule

bind rv32i_subset_execute_unit_core rvxu_checker u_rvxu_checker (.*);

FILE: verif/rv32i_subset_execute_unit_core_test.sv
module rv32i_subset_execute_unit_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rvxu_pkg::*;

   localparam int DATA_WORDS = 1024;

   // encodings outside the supported subset
   localparam logic [6:0] OPC_JAL   = 7'b1101111;
   localparam logic [6:0] F7_MULDIV = 7'b0000001;
   localparam logic [2:0] F3_BYTE   = 3'd0;
   localparam logic [2:0] F3_SLTU   = 3'd3;

   typedef struct packed {
      logic        reg_written;
      logic [4:0]  dest_reg;
      logic [31:0] write_value;
      logic        branch_cond;
      status_type  status;
   } exec_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [31:0] req_instr_word = '0;
   logic busy;
   logic rsp_strobe;
   logic rsp_reg_written;
   logic [4:0] rsp_dest_reg;
   logic signed [31:0] rsp_write_value;
   logic rsp_branch_cond;
   logic [1:0] rsp_status;

   logic [31:0] arch_regs [32];
   logic [31:0] data_mem [DATA_WORDS];
   exec_result_type pending_results [$];

   int n_sent = 0;
   int n_checked = 0;
   int n_errors = 0;
   int n_writes = 0;
   int n_taken = 0;
   int n_faults = 0;
   int n_nimp = 0;
   int burst_left = 1;

   rv32i_subset_execute_unit_core #(
      .DATA_WORDS(DATA_WORDS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_instr_word(req_instr_word),
      .rsp_strobe(rsp_strobe),
      .rsp_reg_written(rsp_reg_written),
      .rsp_dest_reg(rsp_dest_reg),
      .rsp_write_value(rsp_write_value),
      .rsp_branch_cond(rsp_branch_cond),
      .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- encoders ----------------
   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OPC_OP};
   endfunction

   function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] opc);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
   endfunction

   // branch offset bits carry no meaning here, so they are random
   function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2);
      logic [11:0] junk;
      junk = 12'($urandom);
      return {junk[11:5], rs2, rs1, f3, junk[4:0], OPC_BRANCH};
   endfunction

   function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd);
      return {imm, rd, OPC_LUI};
   endfunction

   // ---------------- predictor ----------------
   function automatic status_type mem_status(logic [31:0] addr);
      if (addr[1:0] != 2'b00) return ST_ALIGN;
      if ((addr >> 2) >= DATA_WORDS) return ST_RANGE;
      return ST_OK;
   endfunction

   task automatic execute_instr(input logic [31:0] w, output exec_result_type r);
      logic [6:0] opc, f7;
      logic [4:0] rd, rs1, rs2;
      logic [2:0] f3;
      logic [31:0] a, b, imm, soff, addr, value;
      logic has_rd, bcond, wr;
      status_type st;
      opc = w[6:0];
      rd = w[11:7];
      f3 = w[14:12];
      rs1 = w[19:15];
      rs2 = w[24:20];
      f7 = w[31:25];
      a = arch_regs[rs1];
      b = arch_regs[rs2];
      imm = {{20{w[31]}}, w[31:20]};
      soff = {{20{w[31]}}, w[31:25], w[11:7]};
      value = '0;
      bcond = 1'b0;
      has_rd = 1'b0;
      st = ST_OK;
      case (opc)
         OPC_OP: begin
            has_rd = 1'b1;
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_ADD: value = a + b;
                  F3_SLL: value = a << b[4:0];
                  F3_SLT: value = {31'd0, $signed(a) < $signed(b)};
                  F3_XOR: value = a ^ b;
                  F3_SR:  value = a >> b[4:0];
                  F3_OR:  value = a | b;
                  F3_AND: value = a & b;
                  default: st = ST_NIMP;
               endcase
            end else if (f7 == F7_ALT) begin
               case (f3)
                  F3_ADD: value = a - b;
                  F3_SR:  value = $signed(a) >>> b[4:0];
                  default: st = ST_NIMP;
               endcase
            end else begin
               st = ST_NIMP;
            end
         end
         OPC_OPIMM: begin
            has_rd = 1'b1;
            case (f3)
               F3_SLL: begin
                  if (f7 == F7_BASE) value = a << rs2;
                  else st = ST_NIMP;
               end
               F3_SR: begin
                  if (f7 == F7_BASE) value = a >> rs2;
                  else if (f7 == F7_ALT) value = $signed(a) >>> rs2;
                  else st = ST_NIMP;
               end
               F3_ADD: value = a + imm;
               F3_XOR: value = a ^ imm;
               F3_AND: value = a & imm;
               F3_OR:  value = a | imm;
               F3_SLT: value = {31'd0, $signed(a) < $signed(imm)};
               default: st = ST_NIMP;
            endcase
         end
         OPC_LOAD: begin
            if (f3 == F3_WORD) begin
               has_rd = 1'b1;
               addr = a + imm;
               st = mem_status(addr);
               if (st == ST_OK) value = data_mem[addr >> 2];
            end else begin
               st = ST_NIMP;
            end
         end
         OPC_STORE: begin
            if (f3 == F3_WORD) begin
               addr = a + soff;
               st = mem_status(addr);
               if (st == ST_OK) data_mem[addr >> 2] = b;
            end else begin
               st = ST_NIMP;
            end
         end
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ:  bcond = (a == b);
               F3_BNE:  bcond = (a != b);
               F3_BLT:  bcond = ($signed(a) < $signed(b));
               F3_BGE:  bcond = !($signed(a) < $signed(b));
               F3_BLTU: bcond = (a < b);
               F3_BGEU: bcond = (a >= b);
               default: st = ST_NIMP;
            endcase
         end
         OPC_LUI: begin
            has_rd = 1'b1;
            value = w & UPPER_MASK;
         end
         default: st = ST_NIMP;
      endcase
      wr = has_rd && (rd != 5'd0) && (st != ST_NIMP);
      if (wr) arch_regs[rd] = value;
      r.reg_written = wr;
      r.dest_reg = wr ? rd : 5'd0;
      r.write_value = wr ? value : 32'd0;
      r.branch_cond = bcond;
      r.status = st;
   endtask

   // ---------------- driver ----------------
   task automatic send_instr(input logic [31:0] w);
      exec_result_type want;
      int gap;
      start <= 1'b1;
      req_instr_word <= w;
      do @(posedge clock); while (busy);
      execute_instr(w, want);
      pending_results.push_back(want);
      n_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            8, 9: gap = $urandom_range(4, 12);
            default: gap = $urandom_range(1, 3);
         endcase
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 16);
      end
   endtask

   // ---------------- checker ----------------
   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: beat %0d %s mismatch: expected %h, actual %h",
                  $time, n_checked, name, want_v, got_v);
         n_errors++;
      end
   endtask

   always @(posedge clock) begin
      exec_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response beat: expected none, actual status %0d value %h",
                     $time, rsp_status, rsp_write_value);
            n_errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("reg_written", 32'(want.reg_written), 32'(rsp_reg_written));
            check_field("dest_reg", 32'(want.dest_reg), 32'(rsp_dest_reg));
            check_field("write_value", want.write_value, rsp_write_value);
            check_field("branch_cond", 32'(want.branch_cond), 32'(rsp_branch_cond));
            check_field("status", 32'(want.status), 32'(rsp_status));
            n_checked++;
            if (want.reg_written) n_writes++;
            if (want.branch_cond) n_taken++;
            if (want.status == ST_ALIGN || want.status == ST_RANGE) n_faults++;
            if (want.status == ST_NIMP) n_nimp++;
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_field_extremes();
      send_instr(enc_u(20'hFFFFF, 5'd1));                          // x1 = FFFFF000
      send_instr(enc_u(20'h80000, 5'd2));                          // x2 = most negative
      send_instr(enc_i(12'h800, 5'd0, F3_ADD, 5'd3, OPC_OPIMM));   // x3 = -2048
      send_instr(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd4, OPC_OPIMM));   // x4 = 2047
      send_instr(enc_i(12'h7FF, 5'd2, F3_OR, 5'd5, OPC_OPIMM));
      send_instr(enc_i(12'hFFF, 5'd1, F3_XOR, 5'd6, OPC_OPIMM));
      send_instr(enc_i(12'h555, 5'd3, F3_AND, 5'd7, OPC_OPIMM));
      send_instr(enc_i(12'h000, 5'd2, F3_SLT, 5'd8, OPC_OPIMM));
      send_instr(enc_i({F7_BASE, 5'd31}, 5'd4, F3_SLL, 5'd9, OPC_OPIMM));
      send_instr(enc_i({F7_BASE, 5'd31}, 5'd2, F3_SR, 5'd10, OPC_OPIMM));
      send_instr(enc_i({F7_ALT, 5'd31}, 5'd2, F3_SR, 5'd11, OPC_OPIMM));
   endtask

   task automatic test_reg_ops();
      send_instr(enc_r(F7_BASE, 5'd2, 5'd2, F3_ADD, 5'd12));       // wraps to zero
      send_instr(enc_r(F7_ALT, 5'd2, 5'd0, F3_ADD, 5'd13));
      // shift amounts come from the low five bits only
      send_instr(enc_r(F7_BASE, 5'd11, 5'd4, F3_SLL, 5'd14));
      send_instr(enc_r(F7_BASE, 5'd10, 5'd11, F3_SR, 5'd15));
      send_instr(enc_r(F7_ALT, 5'd4, 5'd2, F3_SR, 5'd16));
      send_instr(enc_r(F7_BASE, 5'd5, 5'd1, F3_AND, 5'd17));
      send_instr(enc_r(F7_BASE, 5'd6, 5'd2, F3_OR, 5'd18));
      send_instr(enc_r(F7_BASE, 5'd11, 5'd5, F3_XOR, 5'd19));
      send_instr(enc_r(F7_BASE, 5'd2, 5'd4, F3_SLT, 5'd20));
   endtask

   task automatic test_memory_access();
      send_instr(enc_s(12'd2044, 5'd2, 5'd0, F3_WORD));
      send_instr(enc_i(12'd2044, 5'd0, F3_WORD, 5'd21, OPC_LOAD));
      send_instr(enc_i(12'd2045, 5'd4, F3_ADD, 5'd22, OPC_OPIMM)); // x22 = last word addr
      send_instr(enc_s(12'd0, 5'd11, 5'd22, F3_WORD));
      send_instr(enc_i(12'd0, 5'd22, F3_WORD, 5'd23, OPC_LOAD));
      send_instr(enc_i(12'd4, 5'd22, F3_WORD, 5'd24, OPC_LOAD));   // one past the end
      send_instr(enc_i(12'd1, 5'd0, F3_WORD, 5'd25, OPC_LOAD));    // misaligned
      send_instr(enc_s(12'hFFC, 5'd4, 5'd0, F3_WORD));             // negative address
      send_instr(enc_s(12'd6, 5'd4, 5'd0, F3_WORD));               // misaligned store
   endtask

   task automatic test_branches();
      send_instr(enc_b(F3_BEQ, 5'd2, 5'd2));
      send_instr(enc_b(F3_BNE, 5'd2, 5'd4));
      send_instr(enc_b(F3_BLT, 5'd2, 5'd4));
      send_instr(enc_b(F3_BGE, 5'd2, 5'd4));
      send_instr(enc_b(F3_BLTU, 5'd2, 5'd4));
      send_instr(enc_b(F3_BGEU, 5'd2, 5'd4));
   endtask

   task automatic test_unimplemented();
      send_instr(32'h0000_0000);
      send_instr(32'hFFFF_FFFF);
      send_instr({20'h12345, 5'd26, OPC_JAL});
      send_instr(enc_r(F7_BASE, 5'd4, 5'd2, F3_SLTU, 5'd26));
      send_instr(enc_i(12'h001, 5'd2, F3_SLTU, 5'd26, OPC_OPIMM));
      send_instr(enc_r(F7_MULDIV, 5'd4, 5'd2, F3_ADD, 5'd26));
      send_instr(enc_i({F7_ALT, 5'd3}, 5'd2, F3_SLL, 5'd26, OPC_OPIMM));
      send_instr(enc_i(12'd0, 5'd0, F3_BYTE, 5'd26, OPC_LOAD));
      send_instr(enc_s(12'd0, 5'd4, 5'd0, F3_BYTE));
      // reserved branch funct3 codes
      send_instr(enc_b(F3_WORD, 5'd2, 5'd2));
      send_instr(enc_b(F3_SLTU, 5'd2, 5'd2));
      send_instr(enc_i(12'd1, 5'd4, F3_ADD, 5'd0, OPC_OPIMM));     // rd = x0
   endtask

   // x1..x4 serve as address bases during the random stream
   function automatic logic [4:0] pick_rd();
      if ($urandom_range(0, 9) == 0) return 5'($urandom_range(0, 31));
      return 5'($urandom_range(5, 31));
   endfunction

   function automatic logic [31:0] random_instr();
      logic [4:0] rs1, rs2, rd, base;
      logic [11:0] off, imm;
      int unsigned sel, pick;
      rs1 = 5'($urandom);
      rs2 = ($urandom_range(0, 3) == 0) ? rs1 : 5'($urandom);
      rd = pick_rd();
      imm = 12'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 14) off = 12'($urandom_range(0, 511) * 4);
      else if (pick < 17) off = 12'($urandom_range(0, 2047));
      else off = imm;
      pick = $urandom_range(0, 19);
      if (pick < 14) base = 5'($urandom_range(1, 4));
      else if (pick < 17) base = 5'd0;
      else base = rs1;
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
         case ($urandom_range(0, 8))
            0: return enc_r(F7_BASE, rs2, rs1, F3_ADD, rd);
            1: return enc_r(F7_ALT, rs2, rs1, F3_ADD, rd);
            2: return enc_r(F7_BASE, rs2, rs1, F3_SLL, rd);
            3: return enc_r(F7_BASE, rs2, rs1, F3_SLT, rd);
            4: return enc_r(F7_BASE, rs2, rs1, F3_XOR, rd);
            5: return enc_r(F7_BASE, rs2, rs1, F3_SR, rd);
            6: return enc_r(F7_ALT, rs2, rs1, F3_SR, rd);
            7: return enc_r(F7_BASE, rs2, rs1, F3_OR, rd);
            default: return enc_r(F7_BASE, rs2, rs1, F3_AND, rd);
         endcase
      end else if (sel < 38) begin
         case ($urandom_range(0, 7))
            0: return enc_i(imm, rs1, F3_ADD, rd, OPC_OPIMM);
            1: return enc_i(imm, rs1, F3_SLT, rd, OPC_OPIMM);
            2: return enc_i(imm, rs1, F3_XOR, rd, OPC_OPIMM);
            3: return enc_i(imm, rs1, F3_OR, rd, OPC_OPIMM);
            4: return enc_i(imm, rs1, F3_AND, rd, OPC_OPIMM);
            5: return enc_i({F7_BASE, rs2}, rs1, F3_SLL, rd, OPC_OPIMM);
            6: return enc_i({F7_BASE, rs2}, rs1, F3_SR, rd, OPC_OPIMM);
            default: return enc_i({F7_ALT, rs2}, rs1, F3_SR, rd, OPC_OPIMM);
         endcase
      end else if (sel < 44) begin
         // (re)load a base register; stepping from itself reaches the upper half
         base = 5'($urandom_range(1, 4));
         return enc_i(12'($urandom_range(0, 511) * 4), $urandom_range(0, 1) ? base : 5'd0,
                      F3_ADD, base, OPC_OPIMM);
      end else if (sel < 58) begin
         return enc_s(off, rs2, base, F3_WORD);
      end else if (sel < 72) begin
         return enc_i(off, base, F3_WORD, rd, OPC_LOAD);
      end else if (sel < 86) begin
         case ($urandom_range(0, 5))
            0: return enc_b(F3_BEQ, rs1, rs2);
            1: return enc_b(F3_BNE, rs1, rs2);
            2: return enc_b(F3_BLT, rs1, rs2);
            3: return enc_b(F3_BGE, rs1, rs2);
            4: return enc_b(F3_BLTU, rs1, rs2);
            default: return enc_b(F3_BGEU, rs1, rs2);
         endcase
      end else if (sel < 91) begin
         return enc_u(20'($urandom), rd);
      end
      return $urandom;
   endfunction

   task automatic test_random_stream(input int count);
      repeat (count) send_instr(random_instr());
   endtask

   // ---------------- sequence ----------------
   initial begin
      int idle;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      foreach (data_mem[i]) data_mem[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_reg_ops();
      test_memory_access();
      test_branches();
      test_unimplemented();
      test_random_stream(1250);
      start <= 1'b0;

      idle = 0;
      while (pending_results.size() != 0 && idle < 50) begin
         @(posedge clock);
         idle++;
      end
      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected response beats never arrived",
                  $time, pending_results.size());
         n_errors += pending_results.size();
      end

      $display("Executed %0d instructions, checked %0d response beats, %0d field errors.",
               n_sent, n_checked, n_errors);
      $display("  %0d register writes, %0d true branch compares,",
               n_writes, n_taken);
      $display("  %0d memory faults, %0d unimplemented.",
               n_faults, n_nimp);
      if (n_errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("%0t: timeout with %0d response beats outstanding",
               $time, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/rvxu_pkg.sv
hw/rtl/rv32i_subset_execute_unit_core.sv
hw/rtl/rvxu_checker.sv
verif/rv32i_subset_execute_unit_core_test.sv
